/* rtl/core/cbsm_pkg.sv */
package cbsm_pkg;

    // slot store geometry
    localparam int SLOT_N  = 8;
    localparam int SLOT_AW = 3;
    localparam int SLOT_W  = 8;

    // result address width
    localparam int PHYS_W = 21;

    // fixed prg banks for the upper windows
    localparam logic [SLOT_W-1:0] FIXED_PRG_SECOND_LAST = 8'hFE;
    localparam logic [SLOT_W-1:0] FIXED_PRG_LAST        = 8'hFF;

    // cpu register decode
    localparam logic [15:0] REG_DECODE_MASK = 16'hE001;
    localparam logic [15:0] REG_BANK_SELECT = 16'h8000;
    localparam logic [15:0] REG_BANK_DATA   = 16'h8001;
    localparam logic [15:0] REG_MIRROR      = 16'hA000;
    localparam logic [15:0] REG_RAM_CTRL    = 16'hA001;

    // slots used by the prg windows
    localparam logic [SLOT_AW-1:0] SLOT_PRG_A = 3'd6;
    localparam logic [SLOT_AW-1:0] SLOT_PRG_B = 3'd7;

    // configuration register indexes
    localparam logic CFG_PRG_MASK = 1'b0;
    localparam logic CFG_CHR_MASK = 1'b1;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_PRG   = 2'd1,
        CMD_CHR   = 2'd2
    } t_cmd;

    // where the bank number of a translation comes from
    typedef enum logic [1:0] {
        SRC_SLOT  = 2'd0,
        SRC_FE    = 2'd1,
        SRC_FF    = 2'd2,
        SRC_CHR2K = 2'd3
    } t_bank_src;

    // translation request handed from the front end to the translate stage
    typedef struct packed {
        logic        hit;
        logic        is_prg;
        t_bank_src   src;
        logic        bank_lo;
        logic [12:0] offset;
    } t_xreq;

    // slot contents after reset
    function automatic logic [SLOT_W-1:0] slot_reset(input logic [SLOT_AW-1:0] idx);
        logic [SLOT_W-1:0] v;
        case (idx)
            3'd0:    v = 8'd0;
            3'd1:    v = 8'd1;
            3'd2:    v = 8'd4;
            3'd3:    v = 8'd5;
            3'd4:    v = 8'd6;
            3'd5:    v = 8'd7;
            3'd6:    v = 8'd0;
            3'd7:    v = 8'd1;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/core/cbsm_bank_ram.sv */
module cbsm_bank_ram (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_we,
    input  logic [2:0] i_waddr,
    input  logic [7:0] i_wdata,
    input  logic       i_re,
    input  logic [2:0] i_raddr,
    output logic [7:0] o_rdata
);
    import cbsm_pkg::*;

    logic [SLOT_W-1:0]  r_mem [SLOT_N];
    logic [SLOT_N-1:0]  r_valid;
    logic [SLOT_W-1:0]  r_rdata;
    logic               r_rvalid;
    logic [SLOT_AW-1:0] r_raddr;

    // slot array, no reset on the data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
            r_raddr <= i_raddr;
        end
    end

    // per-entry written flags and registered read flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvalid <= r_valid[i_raddr];
            end
        end
    end

    // unwritten entries read as their reset value
    assign o_rdata = r_rvalid ? r_rdata : slot_reset(r_raddr);

endmodule

/* rtl/core/cbsm_xlate.sv */
module cbsm_xlate (
    input  cbsm_pkg::t_xreq i_req,
    input  logic [7:0]      i_slot,
    input  logic [7:0]      i_prg_mask,
    input  logic [7:0]      i_chr_mask,
    output logic [20:0]     o_phys_addr,
    output logic            o_hit
);
    import cbsm_pkg::*;

    logic [SLOT_W-1:0] bank;

    // pick the bank number
    always_comb begin
        case (i_req.src)
            SRC_SLOT:  bank = i_slot;
            SRC_FE:    bank = FIXED_PRG_SECOND_LAST;
            SRC_FF:    bank = FIXED_PRG_LAST;
            SRC_CHR2K: bank = {i_slot[6:0], i_req.bank_lo};
            default:   bank = i_slot;
        endcase
    end

    // mask and form the rom byte address, zero on a miss
    always_comb begin
        if (!i_req.hit) begin
            o_phys_addr = '0;
        end else if (i_req.is_prg) begin
            o_phys_addr = {bank & i_prg_mask, i_req.offset};
        end else begin
            o_phys_addr = {3'b000, bank & i_chr_mask, i_req.offset[9:0]};
        end
        o_hit = i_req.hit;
    end

endmodule

/* rtl/core/cartridge_bank_switch_mapper.sv */
// Bank-switching mapper: each transfer is a cpu register write or a prg/chr
// address to translate, and gives exactly one registered result. A new item
// can be accepted every cycle while o_stall is low; the eight bank slots sit
// in a small synchronous memory that is written or read at the accepting edge,
// so a write followed directly by a translation through the same slot is
// seen without any bubble. The result register holds a stalled result while a
// further item waits in the translate stage. The status outputs show the
// mirroring and work-ram state after the item. No clearing pass after reset.
module cartridge_bank_switch_mapper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [15:0] i_bus_addr,
    input  logic [7:0]  i_write_data,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [20:0] o_phys_addr,
    output logic        o_hit,
    output logic        o_mirror_horizontal,
    output logic        o_wram_readable,
    output logic        o_wram_writable,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import cbsm_pkg::*;

    logic              accept;
    logic              out_ready;
    logic              s1_adv;

    logic [7:0]        r_prg_mask;
    logic [7:0]        r_chr_mask;
    logic [7:0]        r_bank_control;
    logic [7:0]        n_bank_control;
    logic              r_mirror;
    logic              n_mirror;
    logic [1:0]        r_ram_ctrl;
    logic [1:0]        n_ram_ctrl;

    logic              ram_we;
    logic [SLOT_AW-1:0] ram_waddr;
    logic [SLOT_W-1:0] ram_wdata;
    logic              ram_re;
    logic [SLOT_AW-1:0] ram_raddr;
    logic [SLOT_W-1:0] ram_rdata;

    t_xreq             req;
    logic [12:0]       chr_a;

    logic              r_s1_vld;
    t_xreq             r_s1_req;
    logic              r_s1_mirror;
    logic [1:0]        r_s1_ram;

    logic [20:0]       x_phys;
    logic              x_hit;

    logic              r_o_vld;
    logic [20:0]       r_o_phys;
    logic              r_o_hit;
    logic              r_o_mirror;
    logic [1:0]        r_o_ram;

    // handshake
    assign out_ready = !r_o_vld || !i_stall;
    assign s1_adv    = r_s1_vld && out_ready;
    assign o_stall   = r_s1_vld && !out_ready;
    assign accept    = i_valid && !o_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_mask <= 8'hFF;
            r_chr_mask <= 8'hFF;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PRG_MASK: r_prg_mask <= i_cfg_data;
                CFG_CHR_MASK: r_chr_mask <= i_cfg_data;
                default:      r_prg_mask <= r_prg_mask;
            endcase
        end
    end

    // register write decode
    always_comb begin
        n_bank_control = r_bank_control;
        n_mirror       = r_mirror;
        n_ram_ctrl     = r_ram_ctrl;
        ram_we         = 1'b0;
        ram_waddr      = r_bank_control[2:0];
        ram_wdata      = i_write_data;
        if (r_bank_control[2:1] == 2'b00) begin
            ram_wdata = {1'b0, i_write_data[7:1]};
        end
        if (accept && i_cmd == CMD_WRITE) begin
            case (i_bus_addr & REG_DECODE_MASK)
                REG_BANK_SELECT: n_bank_control = i_write_data;
                REG_BANK_DATA:   ram_we         = 1'b1;
                REG_MIRROR:      n_mirror       = i_write_data[0];
                REG_RAM_CTRL:    n_ram_ctrl     = i_write_data[7:6];
                default:         n_mirror       = r_mirror;
            endcase
        end
    end

    // translation setup: slot to read and bank source
    assign chr_a = i_bus_addr[12:0] ^ {r_bank_control[7], 12'h000};

    always_comb begin
        req.hit     = 1'b0;
        req.is_prg  = 1'b0;
        req.src     = SRC_SLOT;
        req.bank_lo = chr_a[10];
        req.offset  = i_bus_addr[12:0];
        ram_raddr   = SLOT_PRG_A;
        if (i_cmd == CMD_PRG) begin
            req.is_prg = 1'b1;
            req.hit    = i_bus_addr[15];
            case (i_bus_addr[14:13])
                2'd0:    req.src = r_bank_control[6] ? SRC_FE : SRC_SLOT;
                2'd1:    ram_raddr = SLOT_PRG_B;
                2'd2:    req.src = r_bank_control[6] ? SRC_SLOT : SRC_FE;
                default: req.src = SRC_FF;
            endcase
        end else if (i_cmd == CMD_CHR) begin
            req.hit    = (i_bus_addr[15:13] == 3'b000);
            req.offset = {3'b000, chr_a[9:0]};
            if (!chr_a[12]) begin
                req.src   = SRC_CHR2K;
                ram_raddr = {2'b00, chr_a[11]};
            end else begin
                ram_raddr = {1'b0, chr_a[11:10]} + 3'd2;
            end
        end
    end

    assign ram_re = accept && req.hit;

    cbsm_bank_ram u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_control <= '0;
            r_mirror       <= 1'b0;
            r_ram_ctrl     <= '0;
        end else begin
            r_bank_control <= n_bank_control;
            r_mirror       <= n_mirror;
            r_ram_ctrl     <= n_ram_ctrl;
        end
    end

    // translate stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_req    <= req;
            r_s1_mirror <= n_mirror;
            r_s1_ram    <= n_ram_ctrl;
        end
    end

    cbsm_xlate u_xlate (
        .i_req       (r_s1_req),
        .i_slot      (ram_rdata),
        .i_prg_mask  (r_prg_mask),
        .i_chr_mask  (r_chr_mask),
        .o_phys_addr (x_phys),
        .o_hit       (x_hit)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (s1_adv) begin
            r_o_vld <= 1'b1;
        end else if (!i_stall) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_phys   <= x_phys;
            r_o_hit    <= x_hit;
            r_o_mirror <= r_s1_mirror;
            r_o_ram    <= r_s1_ram;
        end
    end

    assign o_valid             = r_o_vld;
    assign o_phys_addr         = r_o_phys;
    assign o_hit               = r_o_hit;
    assign o_mirror_horizontal = r_o_mirror;
    assign o_wram_readable     = r_o_ram[1];
    assign o_wram_writable     = r_o_ram[1] && !r_o_ram[0];

`ifndef ASSERT_OFF
    // the slot memory is never read and written by one item
    a_ram_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("slot memory read and write at the same edge");

    // a result without a hit carries a zero address
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld && !r_o_hit |-> r_o_phys == '0)
        else $error("miss result with nonzero address");

    // an accepted item always lands in the translate stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_vld)
        else $error("accepted item lost");

    // the translate stage only stalls the input when the result is blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_o_vld && i_stall)
        else $error("input stalled without a blocked result");
`endif

endmodule
